@@ hdl/tvdc_pkg.sv @@
// Package for the timed valve drive controller: codes, configuration
// defaults and the structs shared between the top level and the drive core.
// No dependencies.
package tvdc_pkg;

   localparam int CFG_WIDTH           = 24;
   localparam int CSR_INDEX_WIDTH     = 3;
   localparam int DEFAULT_TIMER_WIDTH = 24;

   localparam logic [CFG_WIDTH-1:0] FULL_TRAVEL_RESET  = 24'd8000;
   localparam logic [CFG_WIDTH-1:0] TEST_PWR_PER_RESET = 24'd10000;
   localparam logic [CFG_WIDTH-1:0] TEST_PWR_HI_RESET  = 24'd5000;
   localparam logic [CFG_WIDTH-1:0] TEST_DIR_PER_RESET = 24'd20000;
   localparam logic [CFG_WIDTH-1:0] TEST_DIR_HI_RESET  = 24'd10000;

   typedef enum logic [2:0] {
      FUNC_TICK  = 3'd0,
      FUNC_OPEN  = 3'd1,
      FUNC_CLOSE = 3'd2,
      FUNC_ABORT = 3'd3,
      FUNC_INIT  = 3'd4
   } func_type;

   typedef enum logic [2:0] {
      MOTION_UNKNOWN   = 3'd0,
      MOTION_OPENING   = 3'd1,
      MOTION_CLOSING   = 3'd2,
      MOTION_OPEN      = 3'd3,
      MOTION_CLOSED    = 3'd4,
      MOTION_OPEN_INT  = 3'd5,
      MOTION_CLOSE_INT = 3'd6
   } motion_type;

   typedef enum logic [1:0] {
      MODE_NORMAL   = 2'd0,
      MODE_TEST     = 2'd1,
      MODE_DISABLED = 2'd2
   } mode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_VALVE_MODE    = 3'd0,
      CSR_STARTUP_DRIVE = 3'd1,
      CSR_FULL_TRAVEL   = 3'd2,
      CSR_TEST_PWR_PER  = 3'd3,
      CSR_TEST_PWR_HI   = 3'd4,
      CSR_TEST_DIR_PER  = 3'd5,
      CSR_TEST_DIR_HI   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [1:0]           valve_mode;
      logic                 startup_drive;
      logic [CFG_WIDTH-1:0] full_travel_ms;
      logic [CFG_WIDTH-1:0] test_power_period;
      logic [CFG_WIDTH-1:0] test_power_high;
      logic [CFG_WIDTH-1:0] test_dir_period;
      logic [CFG_WIDTH-1:0] test_dir_high;
   } cfg_type;

   typedef struct packed {
      logic       power;
      logic       dir;
      logic       busy;
      motion_type motion;
   } status_type;

endpackage

@@ hdl/tvdc_core.sv @@
// Drive core of the timed valve drive controller: holds the valve state and
// the travel and test counters, and updates them once per stepped beat.
// Depends on tvdc_pkg.
module tvdc_core
   import tvdc_pkg::*;
#(
   parameter int TIMER_WIDTH = DEFAULT_TIMER_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic [2:0] func,
   input  logic       open_hint,
   input  cfg_type    cfg,
   output status_type status
);

   // Counters and settings are compared at the wider of the two widths.
   localparam int CW = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;

   motion_type             motion_ff, motion_in;
   logic                   driving_ff, driving_in;
   logic                   to_open_ff, to_open_in;
   logic [TIMER_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic [TIMER_WIDTH-1:0] phase_ff, phase_in;
   logic [TIMER_WIDTH-1:0] dir_phase_ff, dir_phase_in;
   logic                   power_ff, power_in;
   logic                   dir_ff, dir_in;

   logic [TIMER_WIDTH-1:0] elapsed_inc;
   logic                   travel_done;
   logic [TIMER_WIDTH-1:0] phase_inc;
   logic [TIMER_WIDTH-1:0] dir_phase_inc;
   logic                   phase_wrap;
   logic                   dir_wrap;
   logic [TIMER_WIDTH-1:0] phase_next;
   logic [TIMER_WIDTH-1:0] dir_phase_next;
   logic                   mode_normal;
   logic                   mode_test;

   assign mode_normal = (cfg.valve_mode == MODE_NORMAL);
   assign mode_test   = (cfg.valve_mode == MODE_TEST);

   // The travel counter saturates rather than wrapping.
   assign elapsed_inc = (elapsed_ff != {TIMER_WIDTH{1'b1}}) ?
                        elapsed_ff + TIMER_WIDTH'(1) : elapsed_ff;
   assign travel_done = (CW'(elapsed_inc) >= CW'(cfg.full_travel_ms));

   assign phase_inc      = phase_ff + TIMER_WIDTH'(1);
   assign dir_phase_inc  = dir_phase_ff + TIMER_WIDTH'(1);
   assign phase_wrap     = (CW'(phase_inc) >= CW'(cfg.test_power_period));
   assign dir_wrap       = phase_wrap || (CW'(dir_phase_inc) >= CW'(cfg.test_dir_period));
   assign phase_next     = phase_wrap ? '0 : phase_inc;
   assign dir_phase_next = dir_wrap ? '0 : dir_phase_inc;

   always_comb begin
      motion_in    = motion_ff;
      driving_in   = driving_ff;
      to_open_in   = to_open_ff;
      elapsed_in   = elapsed_ff;
      phase_in     = phase_ff;
      dir_phase_in = dir_phase_ff;
      power_in     = power_ff;
      dir_in       = dir_ff;
      if (step_en) begin
         case (func_type'(func))
            FUNC_TICK: begin
               if (mode_test) begin
                  phase_in     = phase_next;
                  dir_phase_in = dir_phase_next;
                  power_in     = (CW'(phase_next) < CW'(cfg.test_power_high));
                  dir_in       = (CW'(dir_phase_next) < CW'(cfg.test_dir_high));
               end else if (driving_ff) begin
                  elapsed_in = elapsed_inc;
                  if (travel_done) begin
                     power_in   = 1'b0;
                     dir_in     = 1'b0;
                     driving_in = 1'b0;
                     motion_in  = to_open_ff ? MOTION_OPEN : MOTION_CLOSED;
                  end
               end
            end
            FUNC_OPEN, FUNC_CLOSE: begin
               if (mode_normal) begin
                  power_in   = 1'b1;
                  dir_in     = (func_type'(func) == FUNC_OPEN);
                  driving_in = 1'b1;
                  to_open_in = (func_type'(func) == FUNC_OPEN);
                  elapsed_in = '0;
                  motion_in  = (func_type'(func) == FUNC_OPEN) ? MOTION_OPENING
                                                              : MOTION_CLOSING;
               end
            end
            FUNC_ABORT: begin
               if (driving_ff) begin
                  power_in   = 1'b0;
                  dir_in     = 1'b0;
                  driving_in = 1'b0;
                  motion_in  = to_open_ff ? MOTION_OPEN_INT : MOTION_CLOSE_INT;
               end
            end
            FUNC_INIT: begin
               power_in   = 1'b0;
               dir_in     = 1'b0;
               driving_in = 1'b0;
               elapsed_in = '0;
               if (mode_test) begin
                  phase_in     = '0;
                  dir_phase_in = '0;
                  motion_in    = MOTION_UNKNOWN;
               end else if (cfg.startup_drive) begin
                  motion_in = MOTION_UNKNOWN;
               end else begin
                  motion_in = open_hint ? MOTION_OPEN : MOTION_UNKNOWN;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         motion_ff    <= MOTION_UNKNOWN;
         driving_ff   <= 1'b0;
         to_open_ff   <= 1'b0;
         elapsed_ff   <= '0;
         phase_ff     <= '0;
         dir_phase_ff <= '0;
         power_ff     <= 1'b0;
         dir_ff       <= 1'b0;
      end else begin
         motion_ff    <= motion_in;
         driving_ff   <= driving_in;
         to_open_ff   <= to_open_in;
         elapsed_ff   <= elapsed_in;
         phase_ff     <= phase_in;
         dir_phase_ff <= dir_phase_in;
         power_ff     <= power_in;
         dir_ff       <= dir_in;
      end
   end

   assign status.power  = power_ff;
   assign status.dir    = dir_ff;
   assign status.busy   = driving_ff;
   assign status.motion = motion_ff;

endmodule

@@ hdl/timed_valve_drive_controller.sv @@
// Timed valve drive controller top level: configuration registers, input beat register
// and result handshake around the drive core. Depends on tvdc_pkg and tvdc_core.
// A request beat accepted into the input beat register is stepped into the core state
// and result register when the result register is free or being emptied.
// Throughput: one beat per cycle while the result side does not stall.
// Reset: synchronous; configuration defaults reload, valid flags and core state clear.
module timed_valve_drive_controller
   import tvdc_pkg::*;
#(
   parameter int TIMER_WIDTH = DEFAULT_TIMER_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [2:0]                 req_func,
   input  logic                       req_open_hint,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_power_pin,
   output logic                       rsp_dir_pin,
   output logic                       rsp_busy_res,
   output logic [2:0]                 rsp_motion,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   logic       in_valid_ff, in_valid_in;
   logic [2:0] in_func_ff;
   logic       in_open_hint_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       advance;
   logic       req_take;
   status_type status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_VALVE_MODE:    cfg_in.valve_mode        = csr_wdata[1:0];
            CSR_STARTUP_DRIVE: cfg_in.startup_drive     = csr_wdata[0];
            CSR_FULL_TRAVEL:   cfg_in.full_travel_ms    = csr_wdata;
            CSR_TEST_PWR_PER:  cfg_in.test_power_period = csr_wdata;
            CSR_TEST_PWR_HI:   cfg_in.test_power_high   = csr_wdata;
            CSR_TEST_DIR_PER:  cfg_in.test_dir_period   = csr_wdata;
            CSR_TEST_DIR_HI:   cfg_in.test_dir_high     = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.valve_mode        <= MODE_NORMAL;
         cfg_ff.startup_drive     <= 1'b0;
         cfg_ff.full_travel_ms    <= FULL_TRAVEL_RESET;
         cfg_ff.test_power_period <= TEST_PWR_PER_RESET;
         cfg_ff.test_power_high   <= TEST_PWR_HI_RESET;
         cfg_ff.test_dir_period   <= TEST_DIR_PER_RESET;
         cfg_ff.test_dir_high     <= TEST_DIR_HI_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The held beat moves into the core whenever the result register is free
   // or being emptied in this cycle.
   assign advance      = !rsp_valid_ff || !rsp_stall;
   assign req_stall    = in_valid_ff && !advance;
   assign req_take     = req_valid && !req_stall;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = (in_valid_ff && advance) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_func_ff      <= req_func;
         in_open_hint_ff <= req_open_hint;
      end
   end

   tvdc_core #(
      .TIMER_WIDTH(TIMER_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (in_valid_ff && advance),
      .func      (in_func_ff),
      .open_hint (in_open_hint_ff),
      .cfg       (cfg_ff),
      .status    (status)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_power_pin = status.power;
   assign rsp_dir_pin   = status.dir;
   assign rsp_busy_res  = status.busy;
   assign rsp_motion    = status.motion;

   // A drive in progress and a travelling motion code always go together.
   assert property (@(posedge clock) disable iff (reset)
      rsp_busy_res == ((rsp_motion == MOTION_OPENING) || (rsp_motion == MOTION_CLOSING)))
   else $error("busy and motion code disagree");

   // A held beat is not dropped while the result side is blocked.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && rsp_stall) |=> in_valid_ff)
   else $error("held request beat lost under stall");

   // A result that is not taken stays offered.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(status)))
   else $error("stalled result changed or vanished");

endmodule

@@ sim/tb_timed_valve_drive_controller.sv @@
// Self-checking testbench for timed_valve_drive_controller: directed and random
// command/tick beats across drive, test, disabled and spare modes, checked beat by beat.
// Depends on tvdc_pkg and the timed_valve_drive_controller RTL.
`timescale 1ns / 100ps

module tb_timed_valve_drive_controller;
   import tvdc_pkg::*;

   localparam int TW             = DEFAULT_TIMER_WIDTH;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 300;
   localparam int TAIL_CYCLES    = 10;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 70;

   localparam logic [1:0]           MODE_SPARE     = 2'd3;
   localparam logic [2:0]           FUNC_SPARE_LO  = 3'd5;
   localparam logic [2:0]           FUNC_SPARE_HI  = 3'd7;
   localparam logic [CFG_WIDTH-1:0] CFG_MAX        = '1;

   typedef struct packed {
      logic [2:0] func;
      logic       open_hint;
   } valve_cmd_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [2:0]                 req_func = 3'd0;
   logic                       req_open_hint = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_power_pin;
   logic                       rsp_dir_pin;
   logic                       rsp_busy_res;
   logic [2:0]                 rsp_motion;
   logic                       csr_write_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CFG_WIDTH-1:0]       csr_wdata = '0;

   // Stimulus and scoreboard
   valve_cmd_type cmd_queue[$];
   status_type status_queue[$];
   int         items_queued = 0;
   int         items_accepted = 0;
   int         results_checked = 0;
   int         error_count = 0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   logic       rsp_hold_go = 1'b0;
   int         rsp_hold_left = 0;
   int         quiet_cycles = 0;
   int         send_pct_plan [4] = '{0, 67, 0, 13};
   int         recv_pct_plan [4] = '{0, 0, 67, 13};

   // Shadow configuration and predicted valve state
   cfg_type    shadow_cfg;
   motion_type valve_pos = MOTION_UNKNOWN;
   logic       drv_active = 1'b0;
   logic       drv_to_open = 1'b0;
   logic [TW-1:0] drv_ticks = '0;
   logic [TW-1:0] tst_pwr_phase = '0;
   logic [TW-1:0] tst_dir_phase = '0;
   logic       pwr_line = 1'b0;
   logic       dir_line = 1'b0;

   timed_valve_drive_controller dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_open_hint  (req_open_hint),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_power_pin  (rsp_power_pin),
      .rsp_dir_pin    (rsp_dir_pin),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_motion     (rsp_motion),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Advances the shadow valve by one beat and returns the status it should report.
   function automatic status_type valve_predict(valve_cmd_type beat);
      logic [TW-1:0] pwr_next;
      logic [TW-1:0] dir_next;
      status_type    st;
      case (beat.func)
         FUNC_TICK: begin
            if (shadow_cfg.valve_mode == MODE_TEST) begin
               pwr_next = tst_pwr_phase + 1'b1;
               dir_next = tst_dir_phase + 1'b1;
               // A wrap of the power phase also restarts the direction phase.
               if (pwr_next >= shadow_cfg.test_power_period) begin
                  pwr_next = '0;
                  dir_next = '0;
               end else if (dir_next >= shadow_cfg.test_dir_period) begin
                  dir_next = '0;
               end
               tst_pwr_phase = pwr_next;
               tst_dir_phase = dir_next;
               pwr_line = (pwr_next < shadow_cfg.test_power_high);
               dir_line = (dir_next < shadow_cfg.test_dir_high);
            end else if (drv_active) begin
               if (drv_ticks != '1)
                  drv_ticks = drv_ticks + 1'b1;
               if (drv_ticks >= shadow_cfg.full_travel_ms) begin
                  pwr_line = 1'b0;
                  dir_line = 1'b0;
                  drv_active = 1'b0;
                  valve_pos = drv_to_open ? MOTION_OPEN : MOTION_CLOSED;
               end
            end
         end
         FUNC_OPEN, FUNC_CLOSE: begin
            if (shadow_cfg.valve_mode == MODE_NORMAL) begin
               drv_to_open = (beat.func == FUNC_OPEN);
               pwr_line = 1'b1;
               dir_line = drv_to_open;
               drv_active = 1'b1;
               drv_ticks = '0;
               valve_pos = drv_to_open ? MOTION_OPENING : MOTION_CLOSING;
            end
         end
         FUNC_ABORT: begin
            if (drv_active) begin
               pwr_line = 1'b0;
               dir_line = 1'b0;
               drv_active = 1'b0;
               valve_pos = drv_to_open ? MOTION_OPEN_INT : MOTION_CLOSE_INT;
            end
         end
         FUNC_INIT: begin
            pwr_line = 1'b0;
            dir_line = 1'b0;
            drv_active = 1'b0;
            drv_ticks = '0;
            if (shadow_cfg.valve_mode == MODE_TEST) begin
               tst_pwr_phase = '0;
               tst_dir_phase = '0;
               valve_pos = MOTION_UNKNOWN;
            end else if (shadow_cfg.startup_drive) begin
               valve_pos = MOTION_UNKNOWN;
            end else begin
               valve_pos = beat.open_hint ? MOTION_OPEN : MOTION_UNKNOWN;
            end
         end
         default: ;
      endcase
      st.power  = pwr_line;
      st.dir    = dir_line;
      st.busy   = drv_active;
      st.motion = valve_pos;
      return st;
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      error_count++;
   endtask

   // Request side: offers queued beats, holding each one until it is taken.
   always @(posedge clock) begin
      valve_cmd_type beat;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            beat.func = req_func;
            beat.open_hint = req_open_hint;
            status_queue.push_back(valve_predict(beat));
            items_accepted++;
         end
         if (req_valid && req_stall) begin
            // stalled: payload stays as it is
         end else if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            beat = cmd_queue.pop_front();
            req_valid <= 1'b1;
            req_func <= beat.func;
            req_open_hint <= beat.open_hint;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, counted here so the random stall can stay independent.
   always @(posedge clock) begin
      if (reset)
         rsp_hold_left <= 0;
      else if (rsp_hold_go)
         rsp_hold_left <= HOLD_CYCLES;
      else if (rsp_hold_left != 0)
         rsp_hold_left <= rsp_hold_left - 1;
   end

   // Result side: checks every accepted beat against the oldest prediction.
   always @(posedge clock) begin
      status_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (status_queue.size() == 0) begin
               report_mismatch("result beat with nothing expected");
            end else begin
               want = status_queue.pop_front();
               if (rsp_power_pin !== want.power)
                  report_mismatch($sformatf("power_pin got %b want %b",
                                            rsp_power_pin, want.power));
               if (rsp_dir_pin !== want.dir)
                  report_mismatch($sformatf("dir_pin got %b want %b",
                                            rsp_dir_pin, want.dir));
               if (rsp_busy_res !== want.busy)
                  report_mismatch($sformatf("busy_res got %b want %b",
                                            rsp_busy_res, want.busy));
               if (rsp_motion !== want.motion)
                  report_mismatch($sformatf("motion got %0d want %0d",
                                            rsp_motion, want.motion));
            end
         end
         rsp_stall <= (rsp_hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Ends the run if work is outstanding and no beat moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (cmd_queue.size() == 0 && status_queue.size() == 0 && !req_valid)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no beat accepted for %0d cycles", quiet_cycles);
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic coin();
      return 1'($urandom_range(1));
   endfunction

   task automatic queue_cmd(logic [2:0] func, logic open_hint);
      valve_cmd_type beat;
      beat.func = func;
      beat.open_hint = open_hint;
      cmd_queue.push_back(beat);
      items_queued++;
   endtask

   // Waits until every queued beat has been taken and every result has come back.
   task automatic drain();
      while (cmd_queue.size() != 0 || status_queue.size() != 0 || req_valid)
         @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CFG_WIDTH-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_VALVE_MODE:    shadow_cfg.valve_mode = value[1:0];
         CSR_STARTUP_DRIVE: shadow_cfg.startup_drive = value[0];
         CSR_FULL_TRAVEL:   shadow_cfg.full_travel_ms = value;
         CSR_TEST_PWR_PER:  shadow_cfg.test_power_period = value;
         CSR_TEST_PWR_HI:   shadow_cfg.test_power_high = value;
         CSR_TEST_DIR_PER:  shadow_cfg.test_dir_period = value;
         CSR_TEST_DIR_HI:   shadow_cfg.test_dir_high = value;
         default: ;
      endcase
   endtask

   // Short travel and test periods so that drives finish and the test lines wrap often.
   task automatic configure(logic [1:0] mode);
      int pwr_period;
      int dir_period;
      pwr_period = $urandom_range(1, 30);
      dir_period = $urandom_range(1, 40);
      write_reg(CSR_VALVE_MODE, CFG_WIDTH'(mode));
      write_reg(CSR_STARTUP_DRIVE, CFG_WIDTH'(coin()));
      write_reg(CSR_FULL_TRAVEL, CFG_WIDTH'($urandom_range(1, 24)));
      write_reg(CSR_TEST_PWR_PER, CFG_WIDTH'(pwr_period));
      write_reg(CSR_TEST_PWR_HI, CFG_WIDTH'($urandom_range(0, pwr_period + 2)));
      write_reg(CSR_TEST_DIR_PER, CFG_WIDTH'(dir_period));
      write_reg(CSR_TEST_DIR_HI, CFG_WIDTH'($urandom_range(0, dir_period + 2)));
   endtask

   // Mostly whole drive sequences (command, a run of ticks, sometimes an interruption),
   // or tick runs in test mode, with some arbitrary beats mixed in.
   task automatic queue_random(int count);
      int target;
      int cap;
      target = items_queued + count;
      while (items_queued < target) begin
         if ($urandom_range(99) < 15) begin
            queue_cmd(3'($urandom_range(7)), coin());
         end else if (shadow_cfg.valve_mode == MODE_TEST) begin
            repeat ($urandom_range(1, 40)) queue_cmd(FUNC_TICK, coin());
            case ($urandom_range(3))
               0: queue_cmd(FUNC_INIT, coin());
               1: queue_cmd(FUNC_ABORT, coin());
               default: ;
            endcase
         end else begin
            queue_cmd(coin() ? FUNC_OPEN : FUNC_CLOSE, coin());
            cap = (shadow_cfg.full_travel_ms < 30) ? int'(shadow_cfg.full_travel_ms) + 2 : 30;
            repeat ($urandom_range(0, cap)) queue_cmd(FUNC_TICK, coin());
            case ($urandom_range(5))
               0: queue_cmd(FUNC_ABORT, coin());
               1: queue_cmd(FUNC_INIT, coin());
               2: queue_cmd(coin() ? FUNC_OPEN : FUNC_CLOSE, coin());
               default: ;
            endcase
         end
      end
   endtask

   initial begin
      logic [1:0] mode_plan [PHASES];
      mode_plan = '{MODE_NORMAL, MODE_TEST, MODE_DISABLED, MODE_NORMAL,
                    MODE_TEST, MODE_SPARE, MODE_NORMAL, MODE_TEST};
      shadow_cfg.valve_mode = MODE_NORMAL;
      shadow_cfg.startup_drive = 1'b0;
      shadow_cfg.full_travel_ms = FULL_TRAVEL_RESET;
      shadow_cfg.test_power_period = TEST_PWR_PER_RESET;
      shadow_cfg.test_power_high = TEST_PWR_HI_RESET;
      shadow_cfg.test_dir_period = TEST_DIR_PER_RESET;
      shadow_cfg.test_dir_high = TEST_DIR_HI_RESET;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset configuration: spare codes, abort while idle, restart, both interruptions,
      // and init with either hint.
      queue_cmd(FUNC_SPARE_LO, 1'b1);
      queue_cmd(FUNC_SPARE_HI, 1'b0);
      queue_cmd(FUNC_ABORT, 1'b0);
      queue_cmd(FUNC_OPEN, 1'b0);
      queue_cmd(FUNC_TICK, 1'b0);
      queue_cmd(FUNC_CLOSE, 1'b0);
      queue_cmd(FUNC_ABORT, 1'b0);
      queue_cmd(FUNC_OPEN, 1'b0);
      queue_cmd(FUNC_ABORT, 1'b0);
      queue_cmd(FUNC_INIT, 1'b1);
      queue_cmd(FUNC_INIT, 1'b0);
      drain();

      // Shortest travel, and init with the startup drive set ignores the hint.
      write_reg(CSR_FULL_TRAVEL, CFG_WIDTH'(1));
      write_reg(CSR_STARTUP_DRIVE, CFG_WIDTH'(1));
      @(negedge clock);
      queue_cmd(FUNC_CLOSE, 1'b1);
      queue_cmd(FUNC_TICK, 1'b0);
      queue_cmd(FUNC_INIT, 1'b1);
      drain();

      // Longest travel; the drive is left running into the next modes.
      write_reg(CSR_FULL_TRAVEL, CFG_MAX);
      write_reg(CSR_STARTUP_DRIVE, CFG_WIDTH'(0));
      @(negedge clock);
      queue_cmd(FUNC_OPEN, 1'b0);
      queue_cmd(FUNC_TICK, 1'b0);
      drain();

      // Test mode with zero periods: counters stay at zero and the drive is frozen.
      write_reg(CSR_TEST_PWR_PER, CFG_WIDTH'(0));
      write_reg(CSR_TEST_DIR_PER, CFG_WIDTH'(0));
      write_reg(CSR_TEST_PWR_HI, CFG_MAX);
      write_reg(CSR_TEST_DIR_HI, CFG_WIDTH'(0));
      write_reg(CSR_VALVE_MODE, CFG_WIDTH'(MODE_TEST));
      @(negedge clock);
      queue_cmd(FUNC_TICK, 1'b0);
      queue_cmd(FUNC_TICK, 1'b1);
      drain();

      // Disabled mode ignores commands but still honours an abort.
      write_reg(CSR_VALVE_MODE, CFG_WIDTH'(MODE_DISABLED));
      @(negedge clock);
      queue_cmd(FUNC_CLOSE, 1'b0);
      queue_cmd(FUNC_TICK, 1'b0);
      queue_cmd(FUNC_ABORT, 1'b0);
      drain();

      write_reg(CSR_VALVE_MODE, CFG_WIDTH'(MODE_SPARE));
      @(negedge clock);
      queue_cmd(FUNC_OPEN, 1'b0);
      drain();

      // Run the test phase up, then lower the period beneath it so it wraps at once.
      write_reg(CSR_TEST_PWR_PER, CFG_WIDTH'(6));
      write_reg(CSR_TEST_PWR_HI, CFG_WIDTH'(3));
      write_reg(CSR_TEST_DIR_PER, CFG_MAX);
      write_reg(CSR_TEST_DIR_HI, CFG_MAX);
      write_reg(CSR_VALVE_MODE, CFG_WIDTH'(MODE_TEST));
      @(negedge clock);
      queue_cmd(FUNC_INIT, 1'b1);
      repeat (4) queue_cmd(FUNC_TICK, 1'b0);
      drain();
      write_reg(CSR_TEST_PWR_PER, CFG_WIDTH'(2));
      @(negedge clock);
      queue_cmd(FUNC_TICK, 1'b0);
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         configure(mode_plan[ph]);
         if (ph == 3)
            write_reg(CSR_FULL_TRAVEL, CFG_WIDTH'(1));
         @(negedge clock);
         send_idle_pct = send_pct_plan[ph % 4];
         recv_stall_pct = recv_pct_plan[ph % 4];
         queue_random(PHASE_ITEMS);
         if (ph == 0) begin
            // Receiver holds off while the sender keeps offering, so the input backs up.
            @(posedge clock);
            rsp_hold_go <= 1'b1;
            @(posedge clock);
            rsp_hold_go <= 1'b0;
         end
         drain();
         @(negedge clock);
         queue_random(PHASE_ITEMS);
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered %0d request beats and %0d result beats over %0d random phases,",
               items_accepted, results_checked, PHASES);
      $display("spanning drive, test, disabled and spare modes under varied back-pressure.");
      if (error_count == 0 && status_queue.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

@@ timed_valve_drive_controller.f @@
hdl/tvdc_pkg.sv
hdl/tvdc_core.sv
hdl/timed_valve_drive_controller.sv
sim/tb_timed_valve_drive_controller.sv
